// ===== design/bli_pkg.sv =====
// ----------------------------------------------------------------------------
// bli_pkg
// Shared types and constants for the line rasterizer with color interpolation.
// ----------------------------------------------------------------------------
package bli_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int NUM_CHAN       = 4;
	localparam int CHAN_BITS      = 8;
	localparam int QUOT_BITS      = CHAN_BITS + 1;
	localparam int CHAN_IDX_BITS  = $clog2(NUM_CHAN);

	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	typedef enum logic [1:0] {
		ST_READY,
		ST_ISSUE,
		ST_WAIT
	} seq_state_t;

endpackage

// ===== design/bli_div.sv =====
// ----------------------------------------------------------------------------
// bli_div
// Shared radix-2 restoring divider: floored quotient and nonnegative
// remainder of a signed channel delta over the major span, one bit a cycle.
// ----------------------------------------------------------------------------
module bli_div #(
	parameter int COORD_BITS = bli_pkg::COORD_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [bli_pkg::QUOT_BITS-1:0] dividend,
	input  logic        [COORD_BITS-1:0]         divisor,
	output logic                                 done,
	output logic signed [bli_pkg::QUOT_BITS-1:0] quot,
	output logic        [COORD_BITS-1:0]         rem
);
	import bli_pkg::*;

	localparam int CNT_W = $clog2(CHAN_BITS);

	logic                        run_q;
	logic                        done_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        neg_q;
	logic [CHAN_BITS-1:0]        mag_q;
	logic [CHAN_BITS-1:0]        quo_q;
	logic [COORD_BITS-1:0]       rem_q;
	logic [COORD_BITS-1:0]       dvs_q;

	logic signed [QUOT_BITS-1:0] neg_dividend;
	logic [CHAN_BITS-1:0]        abs_dividend;
	logic [COORD_BITS:0]         trial;
	logic [COORD_BITS:0]         trial_sub;
	logic                        fits;
	logic [QUOT_BITS-1:0]        q0;
	logic                        rem_nz;

	assign neg_dividend = -dividend;
	assign abs_dividend = dividend[QUOT_BITS-1] ? neg_dividend[CHAN_BITS-1:0]
	                                            : dividend[CHAN_BITS-1:0];

	assign trial     = {rem_q, mag_q[CHAN_BITS-1]};
	assign trial_sub = trial - {1'b0, dvs_q};
	assign fits      = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(CHAN_BITS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[QUOT_BITS-1];
			mag_q <= abs_dividend;
			quo_q <= '0;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			mag_q <= {mag_q[CHAN_BITS-2:0], 1'b0};
			quo_q <= {quo_q[CHAN_BITS-2:0], fits};
			rem_q <= fits ? trial_sub[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
		end
	end

	// floor a negative quotient: -q-1 with remainder folded into [0,divisor)
	assign q0     = {1'b0, quo_q};
	assign rem_nz = |rem_q;
	assign done   = done_q;
	assign quot   = neg_q ? (rem_nz ? signed'(~q0) : signed'(-q0)) : signed'(q0);
	assign rem    = (neg_q && rem_nz) ? (dvs_q - rem_q) : rem_q;

endmodule

// ===== design/bresenham_line_color_interp_top.sv =====
// ----------------------------------------------------------------------------
// bresenham_line_color_interp_top
// Line rasterizer with per-channel color interpolation.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one command word. A start word
// (opcode 0) loads two endpoints and colors; it emits nothing. A step word
// (opcode 1) emits the next pixel of the active line on the output channel
// (out_valid / out_stall), the last one flagged by last; a step while no
// line is active is taken and dropped.
// A pixel is registered and appears on the output in the cycle after its step word.
// Throughput: one step word per cycle while the output drains and no line setup runs.
// Line setup: the four channel slopes are computed by one shared divider,
// one quotient bit per cycle, one channel after another; a start word with
// distinct endpoints holds in_stall high from when it is taken until the
// last slope is stored. A single-point line needs no division and adds no stall.
// Reset clears the sequencer, the active flag and the output valid; no line
// is active afterward. While the receiver stalls a valid output word, the word holds and
// in_stall is raised, so no further word is taken.
// ----------------------------------------------------------------------------
module bresenham_line_color_interp_top #(
	parameter int COORD_BITS = bli_pkg::COORD_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 opcode,
	input  logic [COORD_BITS-1:0]                x_begin,
	input  logic [COORD_BITS-1:0]                y_begin,
	input  logic [COORD_BITS-1:0]                x_end,
	input  logic [COORD_BITS-1:0]                y_end,
	input  logic [bli_pkg::NUM_CHAN*bli_pkg::CHAN_BITS-1:0] color_begin,
	input  logic [bli_pkg::NUM_CHAN*bli_pkg::CHAN_BITS-1:0] color_end,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [COORD_BITS-1:0]                pixel_x,
	output logic [COORD_BITS-1:0]                pixel_y,
	output logic [bli_pkg::CHAN_BITS-1:0]        blue,
	output logic [bli_pkg::CHAN_BITS-1:0]        green,
	output logic [bli_pkg::CHAN_BITS-1:0]        red,
	output logic [bli_pkg::CHAN_BITS-1:0]        alpha,
	output logic                                 last
);
	import bli_pkg::*;

	localparam int ERR_BITS = COORD_BITS + 3;
	localparam int COLOR_BITS = NUM_CHAN * CHAN_BITS;

	// sequencer and control
	seq_state_t               state_q, state_nxt;
	logic [CHAN_IDX_BITS-1:0] chan_q;
	logic                     active_q;
	logic                     out_valid_q;
	logic                     div_start;
	logic                     div_done;
	logic signed [QUOT_BITS-1:0] div_quot;
	logic [COORD_BITS-1:0]    div_rem;
	logic signed [QUOT_BITS-1:0] div_dividend;

	// line state
	logic                     steep_q;
	logic                     down_q;
	logic [COORD_BITS-1:0]    major_q;
	logic [COORD_BITS-1:0]    minor_q;
	logic [COORD_BITS-1:0]    stop_q;
	logic [COORD_BITS-1:0]    span_q;
	logic [COORD_BITS:0]      two_dy_q;
	logic signed [ERR_BITS-1:0] err_q;
	logic [COLOR_BITS-1:0]    c0_q;
	logic [COLOR_BITS-1:0]    c1_q;
	logic [CHAN_BITS-1:0]     val_q  [NUM_CHAN];
	logic signed [QUOT_BITS-1:0] quot_q [NUM_CHAN];
	logic [COORD_BITS-1:0]    srem_q [NUM_CHAN];
	logic [COORD_BITS-1:0]    acc_q  [NUM_CHAN];

	// output word
	logic [COORD_BITS-1:0]    px_q;
	logic [COORD_BITS-1:0]    py_q;
	logic [CHAN_BITS-1:0]     ch_out_q [NUM_CHAN];
	logic                     last_q;

	// handshake
	logic in_acc, start_acc, step_acc, is_last;

	// start setup
	logic [COORD_BITS-1:0] adx, ady;
	logic                  steep;
	logic [COORD_BITS-1:0] mx0, mx1, my0, my1;
	logic                  swap;
	logic [COORD_BITS-1:0] ms, me, ns, ne;
	logic [COLOR_BITS-1:0] cs, ce;
	logic [COORD_BITS-1:0] span_new, dy_new;

	// advance
	logic signed [ERR_BITS-1:0] err_sum;
	logic                       minor_step;
	logic [COORD_BITS:0]        acc_sum [NUM_CHAN];
	logic                       carry   [NUM_CHAN];
	logic [COORD_BITS-1:0]      acc_nxt [NUM_CHAN];
	logic [CHAN_BITS-1:0]       val_nxt [NUM_CHAN];

	assign in_stall  = (state_q != ST_READY) || (out_valid_q && out_stall);
	assign in_acc    = in_valid && !in_stall;
	assign start_acc = in_acc && (opcode == OP_START);
	assign step_acc  = in_acc && (opcode == OP_STEP) && active_q;
	assign is_last   = major_q == stop_q;

	// orient the line: steep lines swap axes, then the major axis must rise
	always_comb begin
		adx      = (x_end > x_begin) ? (x_end - x_begin) : (x_begin - x_end);
		ady      = (y_end > y_begin) ? (y_end - y_begin) : (y_begin - y_end);
		steep    = ady > adx;
		mx0      = steep ? y_begin : x_begin;
		my0      = steep ? x_begin : y_begin;
		mx1      = steep ? y_end   : x_end;
		my1      = steep ? x_end   : y_end;
		swap     = mx0 > mx1;
		ms       = swap ? mx1 : mx0;
		me       = swap ? mx0 : mx1;
		ns       = swap ? my1 : my0;
		ne       = swap ? my0 : my1;
		cs       = swap ? color_end : color_begin;
		ce       = swap ? color_begin : color_end;
		span_new = me - ms;
		dy_new   = (ne > ns) ? (ne - ns) : (ns - ne);
	end

	always_comb begin
		err_sum    = err_q + signed'({2'b00, two_dy_q});
		minor_step = err_sum >= signed'({3'b000, span_q});
		for (int i = 0; i < NUM_CHAN; i++) begin
			acc_sum[i] = {1'b0, acc_q[i]} + {1'b0, srem_q[i]};
			carry[i]   = acc_sum[i] >= {1'b0, span_q};
			acc_nxt[i] = carry[i] ? COORD_BITS'(acc_sum[i] - {1'b0, span_q})
			                      : acc_sum[i][COORD_BITS-1:0];
			val_nxt[i] = val_q[i] + quot_q[i][CHAN_BITS-1:0]
			           + {{(CHAN_BITS-1){1'b0}}, carry[i]};
		end
	end

	assign div_dividend = signed'({1'b0, c1_q[chan_q*CHAN_BITS +: CHAN_BITS]})
	                    - signed'({1'b0, c0_q[chan_q*CHAN_BITS +: CHAN_BITS]});

	bli_div #(
		.COORD_BITS (COORD_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (span_q),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_READY;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		div_start = 1'b0;
		case (state_q)
			ST_READY: begin
				if (start_acc && (span_new != '0)) begin
					state_nxt = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				div_start = 1'b1;
				state_nxt = ST_WAIT;
			end
			ST_WAIT: begin
				if (div_done) begin
					state_nxt = (chan_q == CHAN_IDX_BITS'(NUM_CHAN - 1)) ? ST_READY
					                                                     : ST_ISSUE;
				end
			end
			default: begin
				state_nxt = ST_READY;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q      <= '0;
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (start_acc) begin
				chan_q <= '0;
			end else if (div_done) begin
				chan_q <= chan_q + 1'b1;
			end
			if (start_acc) begin
				active_q <= 1'b1;
			end else if (step_acc && is_last) begin
				active_q <= 1'b0;
			end
			if (step_acc) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_acc) begin
			steep_q  <= steep;
			down_q   <= ns > ne;
			major_q  <= ms;
			minor_q  <= ns;
			stop_q   <= me;
			span_q   <= span_new;
			two_dy_q <= {dy_new, 1'b0};
			err_q    <= '0;
			c0_q     <= cs;
			c1_q     <= ce;
			for (int i = 0; i < NUM_CHAN; i++) begin
				val_q[i] <= cs[i*CHAN_BITS +: CHAN_BITS];
				acc_q[i] <= '0;
			end
		end else if (step_acc && !is_last) begin
			major_q <= major_q + 1'b1;
			if (minor_step) begin
				minor_q <= down_q ? (minor_q - 1'b1) : (minor_q + 1'b1);
				err_q   <= err_sum - signed'({2'b00, span_q, 1'b0});
			end else begin
				err_q   <= err_sum;
			end
			for (int i = 0; i < NUM_CHAN; i++) begin
				val_q[i] <= val_nxt[i];
				acc_q[i] <= acc_nxt[i];
			end
		end
		if (div_done) begin
			quot_q[chan_q] <= div_quot;
			srem_q[chan_q] <= div_rem;
		end
		// load the output word; it holds while the receiver stalls
		if (step_acc) begin
			px_q   <= steep_q ? minor_q : major_q;
			py_q   <= steep_q ? major_q : minor_q;
			last_q <= is_last;
			for (int i = 0; i < NUM_CHAN; i++) begin
				ch_out_q[i] <= val_q[i];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_x   = px_q;
	assign pixel_y   = py_q;
	assign blue      = ch_out_q[0];
	assign green     = ch_out_q[1];
	assign red       = ch_out_q[2];
	assign alpha     = ch_out_q[3];
	assign last      = last_q;

endmodule

// ===== design/bli_check.sv =====
// ----------------------------------------------------------------------------
// bli_check
// Port-level checks for the line rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module bli_check #(
	parameter int COORD_BITS = bli_pkg::COORD_BITS_DEF
) (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_stall,
	input logic                                 opcode,
	input logic [COORD_BITS-1:0]                x_begin,
	input logic [COORD_BITS-1:0]                y_begin,
	input logic [COORD_BITS-1:0]                x_end,
	input logic [COORD_BITS-1:0]                y_end,
	input logic                                 out_valid,
	input logic                                 out_stall,
	input logic [COORD_BITS-1:0]                pixel_x,
	input logic [COORD_BITS-1:0]                pixel_y,
	input logic [bli_pkg::CHAN_BITS-1:0]        blue,
	input logic [bli_pkg::CHAN_BITS-1:0]        green,
	input logic [bli_pkg::CHAN_BITS-1:0]        red,
	input logic [bli_pkg::CHAN_BITS-1:0]        alpha,
	input logic                                 last
);
	import bli_pkg::*;

	logic start_acc;

	assign start_acc = in_valid && !in_stall && (opcode == OP_START);

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
			&& $stable(blue) && $stable(green) && $stable(red) && $stable(alpha)
			&& $stable(last))
		else $error("output word changed while stalled");

	// a start word never produces a pixel
	a_start_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start_acc |=> !$rose(out_valid))
		else $error("start word produced an output word");

	// a line with distinct endpoints runs the slope setup before the next word
	a_setup_stall: assert property (@(posedge clk) disable iff (!arst_n)
		start_acc && ((x_begin != x_end) || (y_begin != y_end)) |=> in_stall)
		else $error("no setup stall after a start word");

	// after a single-point line is loaded, the next stepped pixel is flagged last
	a_point_last: assert property (@(posedge clk) disable iff (!arst_n)
		start_acc && (x_begin == x_end) && (y_begin == y_end)
		##1 (in_valid && !in_stall && (opcode == OP_STEP))
		|=> out_valid && last)
		else $error("single-point line did not end on its first pixel");

endmodule

bind bresenham_line_color_interp_top bli_check #(
	.COORD_BITS (COORD_BITS)
) u_bli_check (.*);
